/* hdl/ptgc_pkg.sv */
// shared types, vocabulary constants and slot tables of the plan token grammar checker
package ptgc_pkg;

    localparam int TOKEN_W = 13;
    localparam int LEN_W   = 8;
    localparam int COUNT_W = 8;

    localparam logic [TOKEN_W-1:0] TOK_OK      = 13'd4097;
    localparam logic [TOKEN_W-1:0] TOK_NO      = 13'd4098;
    localparam logic [TOKEN_W-1:0] TOK_END     = 13'd4099;
    localparam logic [TOKEN_W-1:0] TOK_INTENT0 = 13'd4100;
    localparam logic [TOKEN_W-1:0] TOK_PLACE0  = 13'd4107;
    localparam logic [TOKEN_W-1:0] TOK_UNIT0   = 13'd4109;
    localparam logic [TOKEN_W-1:0] TOK_AMOUNT0 = 13'd4112;
    localparam logic [TOKEN_W-1:0] TOK_SPAN_S0 = 13'd4132;
    localparam logic [TOKEN_W-1:0] TOK_SPAN_E0 = 13'd4260;
    localparam logic [TOKEN_W-1:0] TOK_LIMIT   = 13'd4388;

    localparam logic [2:0] NO_INTENT = 3'd7;
    localparam logic [1:0] SLOT_MAX  = 2'd3;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

    typedef enum logic [1:0] {
        ACT_START = 2'd0,
        ACT_CHECK = 2'd1,
        ACT_STEP  = 2'd2
    } t_action;

    typedef enum logic [1:0] {
        K_PLACE  = 2'd0,
        K_COPY   = 2'd1,
        K_AMOUNT = 2'd2,
        K_UNIT   = 2'd3
    } t_field_kind;

    typedef struct packed {
        logic               gate_seen;
        logic               plan_done;
        logic [2:0]         current_intent;
        logic [1:0]         slot_index;
        logic               span_open;
        logic [6:0]         span_start;
        logic [LEN_W-1:0]   source_count;
        logic [COUNT_W-1:0] actions_opened;
    } t_state;

    localparam t_state STATE_RESET = '{
        gate_seen:      1'b0,
        plan_done:      1'b0,
        current_intent: NO_INTENT,
        slot_index:     2'd0,
        span_open:      1'b0,
        span_start:     7'd0,
        source_count:   8'd0,
        actions_opened: 8'd0
    };

    typedef struct packed {
        logic token_legal;
        logic step_rejected;
    } t_result;

    function automatic logic [1:0] req_slots(input logic [2:0] intent);
        logic [1:0] r;
        case (intent)
            3'd5:    r = 2'd0;
            3'd6:    r = 2'd2;
            default: r = 2'd1;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] all_slots(input logic [2:0] intent);
        logic [1:0] r;
        case (intent)
            3'd0, 3'd3, 3'd4, 3'd6: r = 2'd2;
            3'd1, 3'd2:             r = 2'd1;
            default:                r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic t_field_kind kind_of_slot(input logic [2:0] intent, input logic odd);
        t_field_kind k;
        case (intent)
            3'd0:    k = odd ? K_COPY : K_PLACE;
            3'd1:    k = K_PLACE;
            3'd6:    k = odd ? K_UNIT : K_AMOUNT;
            default: k = K_COPY;
        endcase
        return k;
    endfunction

endpackage

/* hdl/ptgc_step.sv */
// legality check and next-state logic for one token word
module ptgc_step #(
    parameter int MAX_SOURCE       = 128,
    parameter int MAX_PLAN_ACTIONS = 8
) (
    input  ptgc_pkg::t_state                  i_state,
    input  logic [1:0]                        i_action,
    input  logic [ptgc_pkg::TOKEN_W-1:0]      i_token,
    input  logic [ptgc_pkg::LEN_W-1:0]        i_source_len,
    output ptgc_pkg::t_state                  o_next_state,
    output ptgc_pkg::t_result                 o_result
);
    import ptgc_pkg::*;

    localparam logic [LEN_W-1:0]   MAX_SRC = LEN_W'(MAX_SOURCE);
    localparam logic [COUNT_W-1:0] MAX_ACT = COUNT_W'(MAX_PLAN_ACTIONS);

    logic [TOKEN_W-1:0] ss_off;
    logic [TOKEN_W-1:0] se_off;
    logic [TOKEN_W-1:0] cnt_ext;
    logic               is_intent;
    logic               is_span_s;
    logic               is_span_e;
    logic               span_s_ok;
    logic               span_e_ok;
    logic               between_ok;
    logic               kind_hit;
    logic               legal;
    logic [1:0]         slot_inc;
    t_field_kind        kind;

    assign ss_off  = i_token - TOK_SPAN_S0;
    assign se_off  = i_token - TOK_SPAN_E0;
    assign cnt_ext = TOKEN_W'(i_state.source_count);

    assign is_intent = (i_token >= TOK_INTENT0) && (i_token < TOK_PLACE0);
    assign is_span_s = (i_token >= TOK_SPAN_S0) && (i_token < TOK_SPAN_E0);
    assign is_span_e = (i_token >= TOK_SPAN_E0) && (i_token < TOK_LIMIT);

    // span start legal only below the source length
    assign span_s_ok = (i_token >= TOK_SPAN_S0) && (ss_off < cnt_ext);
    // span end must sit at or after the open start
    assign span_e_ok = (i_token >= TOK_SPAN_E0) && (se_off >= TOKEN_W'(i_state.span_start))
                       && (se_off < cnt_ext);

    assign between_ok = ((i_state.actions_opened < MAX_ACT) && is_intent)
                        || ((i_state.actions_opened != '0) && (i_token == TOK_END));

    assign kind = kind_of_slot(i_state.current_intent, i_state.slot_index[0]);

    always_comb begin
        case (kind)
            K_PLACE:  kind_hit = span_s_ok
                                 || ((i_token >= TOK_PLACE0) && (i_token < TOK_UNIT0));
            K_COPY:   kind_hit = span_s_ok;
            K_AMOUNT: kind_hit = (i_token >= TOK_AMOUNT0) && (i_token < TOK_SPAN_S0);
            default:  kind_hit = (i_token >= TOK_UNIT0) && (i_token < TOK_AMOUNT0);
        endcase
    end

    always_comb begin
        if (i_state.plan_done) begin
            legal = 1'b0;
        end else if (!i_state.gate_seen) begin
            legal = (i_token == TOK_OK) || (i_token == TOK_NO);
        end else if (i_state.span_open) begin
            legal = span_e_ok;
        end else if (i_state.current_intent == NO_INTENT) begin
            legal = between_ok;
        end else if (i_state.slot_index >= all_slots(i_state.current_intent)) begin
            legal = between_ok;
        end else if (!kind_hit && (i_state.slot_index >= req_slots(i_state.current_intent)))
        begin
            legal = between_ok;
        end else begin
            legal = kind_hit;
        end
    end

    assign slot_inc = (i_state.slot_index < SLOT_MAX) ? i_state.slot_index + 2'd1
                                                      : i_state.slot_index;

    always_comb begin
        o_next_state           = i_state;
        o_result.token_legal   = 1'b0;
        o_result.step_rejected = 1'b0;
        case (i_action)
            ACT_START: begin
                o_next_state              = STATE_RESET;
                o_next_state.source_count = (i_source_len < MAX_SRC) ? i_source_len : MAX_SRC;
            end
            ACT_CHECK: begin
                o_result.token_legal = legal;
            end
            ACT_STEP: begin
                o_result.token_legal = legal;
                if (i_state.plan_done) begin
                    o_result.step_rejected = 1'b1;
                end else if (!i_state.gate_seen) begin
                    if ((i_token == TOK_OK) || (i_token == TOK_NO)) begin
                        o_next_state.gate_seen = 1'b1;
                        o_next_state.plan_done = (i_token == TOK_NO);
                    end else begin
                        o_result.step_rejected = 1'b1;
                    end
                end else if (i_token == TOK_END) begin
                    o_next_state.plan_done = 1'b1;
                end else if (is_intent) begin
                    o_next_state.current_intent = 3'(i_token - TOK_INTENT0);
                    o_next_state.slot_index     = 2'd0;
                    if (i_state.actions_opened < COUNT_MAX) begin
                        o_next_state.actions_opened = i_state.actions_opened + 8'd1;
                    end
                end else if (is_span_s) begin
                    o_next_state.span_open  = 1'b1;
                    o_next_state.span_start = ss_off[6:0];
                end else begin
                    // span end or any literal fills a slot
                    if (is_span_e) begin
                        o_next_state.span_open = 1'b0;
                    end
                    o_next_state.slot_index = slot_inc;
                    if ((i_state.current_intent != NO_INTENT)
                        && (slot_inc >= all_slots(i_state.current_intent))) begin
                        o_next_state.current_intent = NO_INTENT;
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* hdl/plan_token_grammar_checker.sv */
// top level of the plan token grammar checker: input register, grammar step, result register
//
// Takes one word per clock while input ready is high and returns one result word per input
// word: the word is held in an input register, the grammar step (token range compares
// against the plan state) runs between that register and the result register, and the plan
// state is updated as the result is loaded. A start word clears the plan and latches the
// clamped source length; a check word reports legality only; a step word reports legality and
// consumes the token. Input ready drops only while both the input and the result registers are
// full and the result is not being taken.
module plan_token_grammar_checker #(
    parameter int MAX_SOURCE       = 128,
    parameter int MAX_PLAN_ACTIONS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // token [12:0], source_len [20:13], zero pad
    input  logic [1:0]  s_axis_tuser,   // action [1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // token_legal [0], step_rejected [1], finished [2],
                                        // action_count [10:3], zero pad
);
    import ptgc_pkg::*;

    logic               r_in_vld;
    logic [1:0]         r_in_action;
    logic [TOKEN_W-1:0] r_in_token;
    logic [LEN_W-1:0]   r_in_len;
    t_state             r_state;
    t_state             n_state;
    t_result            n_result;
    logic               r_out_vld;
    t_result            r_out_result;
    logic               r_out_finished;
    logic [COUNT_W-1:0] r_out_count;
    logic               move;

    assign move          = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || move;

    ptgc_step #(
        .MAX_SOURCE       (MAX_SOURCE),
        .MAX_PLAN_ACTIONS (MAX_PLAN_ACTIONS)
    ) u_step (
        .i_state      (r_state),
        .i_action     (r_in_action),
        .i_token      (r_in_token),
        .i_source_len (r_in_len),
        .o_next_state (n_state),
        .o_result     (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_state   <= STATE_RESET;
        end else begin
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (move) begin
                r_out_vld <= 1'b1;
                r_state   <= n_state;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_action <= s_axis_tuser;
            r_in_token  <= s_axis_tdata[12:0];
            r_in_len    <= s_axis_tdata[20:13];
        end
        if (move) begin
            r_out_result   <= n_result;
            r_out_finished <= n_state.plan_done;
            r_out_count    <= n_state.actions_opened;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {5'd0, r_out_count, r_out_finished,
                            r_out_result.step_rejected, r_out_result.token_legal};

`ifndef SYNTHESIS
    // a refused step is never reported as legal
    a_reject_not_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> !(r_out_result.step_rejected && r_out_result.token_legal))
        else $error("rejected step flagged legal");

    // a plan can only close after its gate token
    a_done_after_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.plan_done |-> r_state.gate_seen)
        else $error("plan closed without gate");

    // spans open only after the gate
    a_span_after_gate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.span_open |-> r_state.gate_seen)
        else $error("span open without gate");

    // a held input word is not dropped while the result stage stalls
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !move) |=> (r_in_vld && $stable(r_in_token) && $stable(r_in_action)))
        else $error("stalled input word lost");

    // state moves only when a word passes to the result register
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!move && $past(i_rst_n)) |=> $stable(r_state))
        else $error("plan state changed without a word");
`endif

endmodule

/* bench/plan_token_grammar_checker_chk.sv */
// checker for the plan token grammar checker: tracks the plan state and compares every result word
module plan_token_grammar_checker_chk #(
    parameter int MAX_SOURCE       = 128,
    parameter int MAX_PLAN_ACTIONS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // token [12:0], source_len [20:13], zero pad
    input  logic [1:0]  i_s_axis_tuser,   // action [1:0]
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [15:0] i_m_axis_tdata,   // token_legal [0], step_rejected [1], finished [2],
                                          // action_count [10:3], zero pad
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import ptgc_pkg::*;

    localparam int SHOW_LIMIT = 100;

    typedef struct packed {
        logic               legal;
        logic               refused;
        logic               done;
        logic [COUNT_W-1:0] count;
    } t_verdict;

    // per intent: slots that must be filled, slots in total, and what each slot takes
    localparam int NEEDED_SLOTS [7] = '{1, 1, 1, 1, 1, 0, 2};
    localparam int SLOT_COUNT [7]   = '{2, 1, 1, 2, 2, 0, 2};
    localparam t_field_kind FIELD_KIND [7][2] = '{
        '{K_PLACE, K_COPY}, '{K_PLACE, K_PLACE}, '{K_COPY, K_COPY}, '{K_COPY, K_COPY},
        '{K_COPY, K_COPY}, '{K_COPY, K_COPY}, '{K_AMOUNT, K_UNIT}
    };

    localparam int INTENT_LO = int'(TOK_INTENT0);
    localparam int PLACE_LO  = int'(TOK_PLACE0);
    localparam int UNIT_LO   = int'(TOK_UNIT0);
    localparam int AMOUNT_LO = int'(TOK_AMOUNT0);
    localparam int START_LO  = int'(TOK_SPAN_S0);
    localparam int STOP_LO   = int'(TOK_SPAN_E0);
    localparam int VOCAB_END = int'(TOK_LIMIT);

    t_state   plan = STATE_RESET;
    t_verdict verdict_q[$];

    task automatic note_failure(input string msg);
        o_fail_count++;
        if (o_fail_count <= SHOW_LIMIT) $display("mismatch: %s", msg);
    endtask

    function automatic bit in_window(input int t, input int lo, input int hi);
        return t >= lo && t < hi;
    endfunction

    // between actions: a new intent while under the limit, or end once an action exists
    function automatic bit boundary_ok(input t_state st, input int t);
        if (int'(st.actions_opened) < MAX_PLAN_ACTIONS && in_window(t, INTENT_LO, INTENT_LO + 7))
            return 1'b1;
        return st.actions_opened != '0 && t == int'(TOK_END);
    endfunction

    function automatic bit token_allowed(input t_state st, input int t);
        int it;
        int s;
        int src;
        bit hit;
        src = int'(st.source_count);
        if (st.plan_done) return 1'b0;
        if (!st.gate_seen) return t == int'(TOK_OK) || t == int'(TOK_NO);
        if (st.span_open)
            return in_window(t, STOP_LO + int'(st.span_start), STOP_LO + src);
        if (st.current_intent == NO_INTENT) return boundary_ok(st, t);
        it = int'(st.current_intent);
        s  = int'(st.slot_index);
        if (s >= SLOT_COUNT[it]) return boundary_ok(st, t);
        case (FIELD_KIND[it][s % 2])
            K_PLACE:  hit = in_window(t, START_LO, START_LO + src) ||
                            in_window(t, PLACE_LO, PLACE_LO + 2);
            K_COPY:   hit = in_window(t, START_LO, START_LO + src);
            K_AMOUNT: hit = in_window(t, AMOUNT_LO, AMOUNT_LO + 20);
            default:  hit = in_window(t, UNIT_LO, UNIT_LO + 3);
        endcase
        // an optional slot may be skipped
        if (!hit && s >= NEEDED_SLOTS[it]) hit = boundary_ok(st, t);
        return hit;
    endfunction

    function automatic t_state consume_token(input t_state st, input int t, output bit refused);
        refused = 1'b0;
        if (st.plan_done) begin
            refused = 1'b1;
            return st;
        end
        if (!st.gate_seen) begin
            if (t != int'(TOK_OK) && t != int'(TOK_NO)) begin
                refused = 1'b1;
                return st;
            end
            st.gate_seen = 1'b1;
            if (t == int'(TOK_NO)) st.plan_done = 1'b1;
            return st;
        end
        // after the gate nothing is refused, legality is not looked at
        if (t == int'(TOK_END)) begin
            st.plan_done = 1'b1;
        end else if (in_window(t, INTENT_LO, INTENT_LO + 7)) begin
            st.current_intent = 3'(t - INTENT_LO);
            st.slot_index     = '0;
            if (st.actions_opened != COUNT_MAX) st.actions_opened++;
        end else if (in_window(t, START_LO, STOP_LO)) begin
            st.span_open  = 1'b1;
            st.span_start = 7'(t - START_LO);
        end else begin
            // span end or any literal fills the slot
            if (in_window(t, STOP_LO, VOCAB_END)) st.span_open = 1'b0;
            if (st.slot_index != SLOT_MAX) st.slot_index++;
            if (st.current_intent != NO_INTENT &&
                int'(st.slot_index) >= SLOT_COUNT[int'(st.current_intent)])
                st.current_intent = NO_INTENT;
        end
        return st;
    endfunction

    always @(posedge i_clk) begin : watch
        t_verdict want;
        t_verdict got;
        bit       refused;
        int       tok;
        int       len;
        if (!i_rst_n) begin
            plan = STATE_RESET;
            verdict_q.delete();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                tok  = int'(i_s_axis_tdata[TOKEN_W-1:0]);
                len  = int'(i_s_axis_tdata[TOKEN_W+LEN_W-1:TOKEN_W]);
                want = '0;
                case (i_s_axis_tuser)
                    ACT_START: begin
                        plan = STATE_RESET;
                        plan.source_count = LEN_W'(len < MAX_SOURCE ? len : MAX_SOURCE);
                    end
                    ACT_CHECK: want.legal = token_allowed(plan, tok);
                    ACT_STEP: begin
                        want.legal   = token_allowed(plan, tok);
                        plan         = consume_token(plan, tok, refused);
                        want.refused = refused;
                    end
                    default: ;
                endcase
                want.done  = plan.plan_done;
                want.count = plan.actions_opened;
                verdict_q.push_back(want);
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                got.legal   = i_m_axis_tdata[0];
                got.refused = i_m_axis_tdata[1];
                got.done    = i_m_axis_tdata[2];
                got.count   = i_m_axis_tdata[3 +: COUNT_W];
                if (verdict_q.size() == 0) begin
                    note_failure($sformatf("result word %0d arrived with none pending", o_checked));
                end else begin
                    want = verdict_q.pop_front();
                    if (got.legal !== want.legal)
                        note_failure($sformatf("word %0d: token_legal %b, predicted %b",
                                               o_checked, got.legal, want.legal));
                    if (got.refused !== want.refused)
                        note_failure($sformatf("word %0d: step_rejected %b, predicted %b",
                                               o_checked, got.refused, want.refused));
                    if (got.done !== want.done)
                        note_failure($sformatf("word %0d: finished %b, predicted %b",
                                               o_checked, got.done, want.done));
                    if (got.count !== want.count)
                        note_failure($sformatf("word %0d: action_count %0d, predicted %0d",
                                               o_checked, got.count, want.count));
                end
                o_checked++;
            end
        end
        o_pending = verdict_q.size();
    end

endmodule

/* bench/tb_plan_token_grammar_checker.sv */
// testbench top for the plan token grammar checker: stimulus, idle/stall phases and verdict
module tb_plan_token_grammar_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import ptgc_pkg::*;

    localparam int MAX_SOURCE       = 128;
    localparam int MAX_PLAN_ACTIONS = 8;
    localparam int WORD_TARGET      = 950;
    localparam int LONG_PLAN        = 260;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int DRAIN_CYCLES     = 12;

    localparam logic [1:0] ACT_SPARE = 2'd3;

    localparam int INTENT_MOVE = 0;
    localparam int INTENT_STOP = 5;
    localparam int INTENT_WAIT = 6;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata  = '0;   // token [12:0], source_len [20:13], zero pad
    logic [1:0]  s_axis_tuser  = '0;   // action [1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b1;
    logic [15:0] m_axis_tdata;         // token_legal [0], step_rejected [1], finished [2],
                                       // action_count [10:3], zero pad

    int fail_count;
    int pending;
    int checked;
    int cycles     = 0;
    int words_sent = 0;
    int plans_sent = 0;
    int gap_pct    = 0;
    int stall_pct  = 0;
    int cur_lim    = 0;

    always #4 i_clk = ~i_clk;

    plan_token_grammar_checker #(
        .MAX_SOURCE       (MAX_SOURCE),
        .MAX_PLAN_ACTIONS (MAX_PLAN_ACTIONS)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    plan_token_grammar_checker_chk #(
        .MAX_SOURCE       (MAX_SOURCE),
        .MAX_PLAN_ACTIONS (MAX_PLAN_ACTIONS)
    ) u_grammar_chk (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending       (pending),
        .o_checked       (checked)
    );

    always @(negedge i_clk) begin
        m_axis_tready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout with %0d result words outstanding", pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // one word, entered and left at a falling edge
    task automatic put_word(input logic [1:0] act, input logic [TOKEN_W-1:0] tok,
                            input logic [LEN_W-1:0] len);
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(negedge i_clk); while ($urandom_range(99) < gap_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {3'b000, len, tok};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        words_sent++;
    endtask

    // sender holds off until every result has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    function automatic logic [TOKEN_W-1:0] any_token();
        case ($urandom_range(9))
            0:       return TOKEN_W'($urandom);
            1:       return TOKEN_W'($urandom_range(TOK_OK, TOK_END));
            2:       return TOKEN_W'(TOK_INTENT0 + $urandom_range(6));
            3:       return TOKEN_W'($urandom_range(TOK_PLACE0, TOK_SPAN_S0 - 1));
            4, 5:    return TOKEN_W'(TOK_SPAN_S0 + $urandom_range(127));
            6, 7:    return TOKEN_W'(TOK_SPAN_E0 + $urandom_range(127));
            8:       return TOKEN_W'($urandom_range(4096));
            default: begin
                case ($urandom_range(3))
                    0:       return TOK_LIMIT;
                    1:       return TOKEN_W'(TOK_SPAN_E0 + cur_lim);
                    2:       return TOKEN_W'(TOK_SPAN_S0 + cur_lim);
                    default: return TOKEN_W'(TOK_OK - 1);
                endcase
            end
        endcase
    endfunction

    task automatic put_noise();
        case ($urandom_range(2))
            0:       put_word(ACT_CHECK, any_token(), LEN_W'($urandom));
            1:       put_word(ACT_STEP, any_token(), LEN_W'($urandom));
            default: put_word(ACT_SPARE, any_token(), LEN_W'($urandom));
        endcase
    endtask

    // a step, now and then preceded by a check of the same or another token
    task automatic put_step(input logic [TOKEN_W-1:0] tok);
        if ($urandom_range(3) == 0)
            put_word(ACT_CHECK, $urandom_range(1) ? tok : any_token(), LEN_W'($urandom));
        put_word(ACT_STEP, tok, LEN_W'($urandom));
    endtask

    task automatic put_span();
        int hi;
        int first;
        hi    = (cur_lim == 0) ? 128 : cur_lim;
        first = $urandom_range(hi - 1);
        put_step(TOKEN_W'(TOK_SPAN_S0 + first));
        put_step(TOKEN_W'(TOK_SPAN_E0 + $urandom_range(hi - 1, first)));
    endtask

    task automatic put_slot_value(input t_field_kind kind);
        case (kind)
            K_PLACE: begin
                if ($urandom_range(1)) put_step(TOKEN_W'(TOK_PLACE0 + $urandom_range(1)));
                else put_span();
            end
            K_COPY:   put_span();
            K_AMOUNT: put_step(TOKEN_W'(TOK_AMOUNT0 + $urandom_range(19)));
            default:  put_step(TOKEN_W'(TOK_UNIT0 + $urandom_range(2)));
        endcase
    endtask

    // a well-formed plan with random content, bent out of shape now and then
    task automatic put_plan(input int action_total, input bit with_slots);
        int roll;
        int len;
        int intent;
        roll = $urandom_range(99);
        if (roll < 10)      len = 0;
        else if (roll < 20) len = $urandom_range(255, 129);
        else if (roll < 35) len = $urandom_range(4, 1);
        else                len = $urandom_range(128, 1);
        cur_lim = (len > MAX_SOURCE) ? MAX_SOURCE : len;
        put_word(ACT_START, TOKEN_W'($urandom), LEN_W'(len));
        plans_sent++;
        roll = $urandom_range(99);
        if (roll < 6) begin
            put_step(TOK_NO);
            repeat ($urandom_range(2)) put_noise();
            return;
        end
        if (roll < 12) put_step(any_token());
        put_step(TOK_OK);
        for (int a = 0; a < action_total; a++) begin
            if (with_slots && $urandom_range(19) == 0) put_noise();
            intent = $urandom_range(6);
            put_step(TOKEN_W'(TOK_INTENT0 + intent));
            if (with_slots) begin
                for (int s = 0; s < int'(all_slots(3'(intent))); s++) begin
                    if (s >= int'(req_slots(3'(intent))) && $urandom_range(2) == 0) break;
                    put_slot_value(kind_of_slot(3'(intent), s[0]));
                end
            end
        end
        if ($urandom_range(9) != 0) put_step(TOK_END);
        repeat ($urandom_range(2)) put_noise();
    endtask

    initial begin
        int base;
        int phase;
        int last_phase;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: gate, clamp, slot kinds, span order, optional slot, closed plan, refusal
        put_word(ACT_STEP, '0, '0);
        put_word(ACT_SPARE, '1, '1);
        put_word(ACT_START, '1, 8'd255);
        put_word(ACT_CHECK, TOK_OK, '0);
        put_word(ACT_CHECK, TOK_NO, '0);
        put_word(ACT_CHECK, TOK_END, '0);
        put_word(ACT_STEP, '1, '0);
        put_word(ACT_STEP, TOK_OK, '0);
        put_word(ACT_CHECK, TOK_END, '0);
        put_word(ACT_STEP, TOKEN_W'(TOK_INTENT0 + INTENT_WAIT), '0);
        put_word(ACT_CHECK, TOK_END, '0);
        put_word(ACT_STEP, TOKEN_W'(TOK_AMOUNT0 + 19), '0);
        put_word(ACT_STEP, TOKEN_W'(TOK_UNIT0 + 2), '0);
        put_word(ACT_STEP, TOKEN_W'(TOK_INTENT0 + INTENT_MOVE), '0);
        put_word(ACT_STEP, TOKEN_W'(TOK_SPAN_S0 + 127), '0);
        put_word(ACT_CHECK, TOKEN_W'(TOK_SPAN_E0 + 126), '0);
        put_word(ACT_STEP, TOKEN_W'(TOK_LIMIT - 1), '0);
        put_word(ACT_CHECK, TOK_END, '0);
        put_word(ACT_STEP, TOK_END, '0);
        put_word(ACT_STEP, TOK_OK, '0);
        put_word(ACT_CHECK, TOK_OK, '0);
        put_word(ACT_START, '0, '0);
        put_word(ACT_STEP, TOK_NO, '0);
        put_word(ACT_START, '0, 8'd1);
        put_word(ACT_STEP, TOK_OK, '0);
        put_word(ACT_STEP, TOKEN_W'(TOK_INTENT0 + INTENT_STOP), '0);
        put_word(ACT_CHECK, TOK_END, '0);

        // one long plan drives the action counter past the limit into saturation
        put_plan(LONG_PLAN, 1'b0);

        base       = words_sent;
        last_phase = -1;
        while (words_sent < WORD_TARGET) begin
            phase = (words_sent - base) * 4 / (WORD_TARGET - base);
            if (phase > 3) phase = 3;
            if (phase != last_phase) begin
                settle();
                case (phase)
                    0:       begin gap_pct = 0;  stall_pct = 0;  end
                    1:       begin gap_pct = 84; stall_pct = 0;  end
                    2:       begin gap_pct = 0;  stall_pct = 84; end
                    default: begin gap_pct = 25; stall_pct = 25; end
                endcase
                last_phase = phase;
            end
            put_plan($urandom_range(MAX_PLAN_ACTIONS + 2), 1'b1);
        end

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d words in %0d plans over four idle/stall mixes, %0d results compared",
                 words_sent, plans_sent, checked);
        $display("gate refusal, span order, optional slots, action limit and counter saturation");
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* plan_token_grammar_checker.f */
hdl/ptgc_pkg.sv
hdl/ptgc_step.sv
hdl/plan_token_grammar_checker.sv
bench/plan_token_grammar_checker_chk.sv
bench/tb_plan_token_grammar_checker.sv
